/* hdl/rrc_pkg.sv */
// Shared types and constants for the rotated rectangle corner generator.
// No dependencies; every hdl file imports this package.
package rrc_pkg;

  // Field widths
  localparam int CX_W   = 20;   // center coordinate, signed 1/16 pixel
  localparam int SIZE_W = 16;   // full width / height, unsigned 1/16 pixel
  localparam int ANG_W  = 16;   // angle, signed 1/16 degree
  localparam int OUT_W  = 21;   // corner coordinate, signed 1/16 pixel

  // CORDIC datapath: x, y in Q2.30 with headroom, z as phase of 2^32 per turn
  localparam int XY_W = 33;
  localparam int Z_W  = 32;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;

  // Start vector pre-scaled by the CORDIC gain, Q30
  localparam logic signed [XY_W-1:0] GAIN_Q30 = 33'sd652032874;

  // Angle reduction: 5760 = 45 * 2^7
  localparam int TURN_UNITS  = 5760;
  localparam int ANG_BIAS    = 6 * TURN_UNITS;
  localparam int SECTOR      = 45;
  localparam int RECIP_45    = 5826;    // ceil(2^18 / 45), exact for x < 10082
  localparam int RECIP_SH    = 18;
  localparam int PHASE_PER_R = 745654;  // floor(2^25 / 45)
  localparam int R_CARRY1    = 12;      // remainder where the rounding term gains 1
  localparam int R_CARRY2    = 34;      // remainder where it gains 2

  // atan(2^-i) in units of 2^32 per turn
  typedef logic signed [Z_W-1:0] atan_tab_t [ATAN_ENTRIES];
  localparam atan_tab_t ATAN_TURN32 = '{
    32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
    32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
    32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
    32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA, 32'sh0000517D,
    32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
    32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051
  };

  // Rectangle geometry carried alongside the angle path
  typedef struct packed {
    logic signed [CX_W-1:0] cx;
    logic signed [CX_W-1:0] cy;
    logic [SIZE_W-1:0]      w;
    logic [SIZE_W-1:0]      h;
  } geom_t;

endpackage

/* hdl/rrc_phase.sv */
// Angle reduction: 1/16 degree angle to a CORDIC phase in [-90, 90] degrees
// plus a half-turn flag. Three register stages. Depends on rrc_pkg.
module rrc_phase
  import rrc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rect_valid,
  output logic                   rect_ready,
  input  logic signed [ANG_W-1:0] angle,
  input  geom_t                  rect_geom,
  output logic                   ph_valid,
  input  logic                   ph_ready,
  output logic signed [Z_W-1:0]  ph_z,
  output logic                   ph_flip,
  output geom_t                  ph_geom
);

  localparam int SUB_W = 7;              // 5760 = 45 << 7
  localparam int U_W   = ANG_W + 1;
  localparam int HI_W  = U_W - SUB_W;
  localparam int A_W   = 13;             // reduced angle < 5760
  localparam int Q_W   = 7;
  localparam int R_W   = 6;
  localparam int PH_SH = Z_W - SUB_W;    // 2^32 / 5760 = 2^25 / 45

  localparam logic signed [Z_W-1:0] QTR_POS   = 32'sh4000_0000;
  localparam logic signed [Z_W-1:0] QTR_NEG   = 32'shC000_0000;
  localparam logic signed [Z_W-1:0] HALF_TURN = 32'sh8000_0000;

  logic [2:0] v;
  logic       en;

  logic [A_W-1:0] a0;
  geom_t          g0;
  logic [Q_W-1:0] q1;
  logic [R_W-1:0] r1;
  geom_t          g1;

  // stage 0: bias to positive, then fold the high part modulo 45
  logic signed [U_W:0]    ang_b;
  logic [U_W-1:0]         ang_u;
  logic [HI_W-1:0]        hi;
  logic [HI_W+11:0]       hi_prod;
  logic [3:0]             hi_q;
  logic [HI_W-1:0]        hi_rem;
  logic [A_W-1:0]         a_next;

  // stage 1: split reduced angle into quotient and remainder by 45
  logic [A_W+11:0]        a_prod;
  logic [Q_W-1:0]         q_next;
  logic [A_W-1:0]         r_full;

  // stage 2: phase and quadrant fold
  logic [Z_W-1:0]         ph_u;
  logic signed [Z_W-1:0]  ph_s;
  logic signed [Z_W-1:0]  z_next;
  logic                   flip_next;

  assign en         = !v[2] || ph_ready;
  assign rect_ready = en;
  assign ph_valid   = v[2];

  always_comb begin
    ang_b   = {{2{angle[ANG_W-1]}}, angle} + (U_W+1)'(ANG_BIAS);
    ang_u   = ang_b[U_W-1:0];
    hi      = ang_u[U_W-1:SUB_W];
    hi_prod = (HI_W+12)'(hi) * (HI_W+12)'(RECIP_45);
    hi_q    = hi_prod[RECIP_SH +: 4];
    hi_rem  = hi - HI_W'(hi_q) * HI_W'(SECTOR);
    a_next  = {hi_rem[R_W-1:0], ang_u[SUB_W-1:0]};
  end

  always_comb begin
    a_prod = (A_W+12)'(a0) * (A_W+12)'(RECIP_45);
    q_next = a_prod[RECIP_SH +: Q_W];
    r_full = a0 - A_W'(q_next) * A_W'(SECTOR);
  end

  always_comb begin
    ph_u = {q1, {PH_SH{1'b0}}} + Z_W'(r1) * Z_W'(PHASE_PER_R)
         + Z_W'(r1 >= R_W'(R_CARRY1)) + Z_W'(r1 >= R_W'(R_CARRY2));
    ph_s = ph_u;
    if (ph_s > QTR_POS || ph_s < QTR_NEG) begin
      z_next    = ph_s - HALF_TURN;
      flip_next = 1'b1;
    end else begin
      z_next    = ph_s;
      flip_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[1:0], rect_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0      <= a_next;
      g0      <= rect_geom;
      q1      <= q_next;
      r1      <= r_full[R_W-1:0];
      g1      <= g0;
      ph_z    <= z_next;
      ph_flip <= flip_next;
      ph_geom <= g1;
    end
  end

endmodule

/* hdl/rrc_cordic.sv */
// Rotation-mode CORDIC, one register stage per iteration, gain pre-applied.
// Carries the flip flag and geometry alongside. Depends on rrc_pkg.
module rrc_cordic
  import rrc_pkg::*;
#(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   ph_valid,
  output logic                   ph_ready,
  input  logic signed [Z_W-1:0]  ph_z,
  input  logic                   ph_flip,
  input  geom_t                  ph_geom,
  output logic                   dir_valid,
  input  logic                   dir_ready,
  output logic signed [XY_W-1:0] dir_x,
  output logic signed [XY_W-1:0] dir_y,
  output logic                   dir_flip,
  output geom_t                  dir_geom
);

  logic [STEPS-1:0] v;
  logic [STEPS-1:0] f;
  logic             en;

  logic signed [XY_W-1:0] x  [STEPS];
  logic signed [XY_W-1:0] y  [STEPS];
  logic signed [Z_W-1:0]  z  [STEPS];
  geom_t                  g  [STEPS];

  logic signed [XY_W-1:0] xp [STEPS];
  logic signed [XY_W-1:0] yp [STEPS];
  logic signed [Z_W-1:0]  zp [STEPS];
  logic signed [XY_W-1:0] xn [STEPS];
  logic signed [XY_W-1:0] yn [STEPS];
  logic signed [Z_W-1:0]  zn [STEPS];

  assign en        = !v[STEPS-1] || dir_ready;
  assign ph_ready  = en;
  assign dir_valid = v[STEPS-1];
  assign dir_x     = x[STEPS-1];
  assign dir_y     = y[STEPS-1];
  assign dir_flip  = f[STEPS-1];
  assign dir_geom  = g[STEPS-1];

  // each stage i rotates by +-atan(2^-i), steered by the sign of residual z
  always_comb begin
    xp[0] = GAIN_Q30;
    yp[0] = '0;
    zp[0] = ph_z;
    for (int i = 1; i < STEPS; i++) begin
      xp[i] = x[i-1];
      yp[i] = y[i-1];
      zp[i] = z[i-1];
    end
    for (int i = 0; i < STEPS; i++) begin
      if (zp[i] >= 0) begin
        xn[i] = xp[i] - (yp[i] >>> i);
        yn[i] = yp[i] + (xp[i] >>> i);
        zn[i] = zp[i] - ATAN_TURN32[i];
      end else begin
        xn[i] = xp[i] + (yp[i] >>> i);
        yn[i] = yp[i] - (xp[i] >>> i);
        zn[i] = zp[i] + ATAN_TURN32[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[STEPS-2:0], ph_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f    <= {f[STEPS-2:0], ph_flip};
      g[0] <= ph_geom;
      for (int i = 1; i < STEPS; i++) begin
        g[i] <= g[i-1];
      end
      for (int i = 0; i < STEPS; i++) begin
        x[i] <= xn[i];
        y[i] <= yn[i];
        z[i] <= zn[i];
      end
    end
  end

endmodule

/* hdl/rrc_corners.sv */
// Corner stage: undo the half-turn, scale the direction by width and height,
// form the four rotated offsets, round and add the center. Four register
// stages, the last one is the output register. Depends on rrc_pkg.
module rrc_corners
  import rrc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    dir_valid,
  output logic                    dir_ready,
  input  logic signed [XY_W-1:0]  dir_x,
  input  logic signed [XY_W-1:0]  dir_y,
  input  logic                    dir_flip,
  input  geom_t                   dir_geom,
  output logic                    corner_valid,
  input  logic                    corner_ready,
  output logic signed [OUT_W-1:0] top_left_x,
  output logic signed [OUT_W-1:0] top_left_y,
  output logic signed [OUT_W-1:0] top_right_x,
  output logic signed [OUT_W-1:0] top_right_y,
  output logic signed [OUT_W-1:0] bottom_right_x,
  output logic signed [OUT_W-1:0] bottom_right_y,
  output logic signed [OUT_W-1:0] bottom_left_x,
  output logic signed [OUT_W-1:0] bottom_left_y
);

  localparam int PROD_W = XY_W + SIZE_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RND_SH = 31;
  localparam int RND_W  = SUM_W - RND_SH;

  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(64'sd1 <<< (RND_SH - 1));
  localparam logic signed [OUT_W:0]   SAT_HI   = (OUT_W+1)'((64'sd1 <<< (OUT_W - 1)) - 1);
  localparam logic signed [OUT_W:0]   SAT_LO   = -SAT_HI - (OUT_W+1)'(1);

  logic [3:0] v;
  logic       en;

  logic signed [XY_W-1:0]   c0, s0;
  geom_t                    g0;
  logic signed [PROD_W-1:0] cw1, sh1, sw1, ch1;
  geom_t                    g1;
  logic signed [SUM_W-1:0]  tlx2, tly2, trx2, try2, brx2, bry2, blx2, bly2;
  geom_t                    g2;

  logic signed [SIZE_W:0]   w_s, h_s;

  // round to 1/16 pixel (half up), add center, clamp to the output range
  function automatic logic signed [OUT_W-1:0] place(
    input logic signed [CX_W-1:0]  ctr,
    input logic signed [SUM_W-1:0] off
  );
    logic signed [SUM_W-1:0] t;
    logic signed [RND_W-1:0] r;
    logic signed [OUT_W:0]   s;
    t = off + RND_HALF;
    r = t[SUM_W-1:RND_SH];
    s = (OUT_W+1)'(ctr) + (OUT_W+1)'(r);
    if (s > SAT_HI) begin
      s = SAT_HI;
    end else if (s < SAT_LO) begin
      s = SAT_LO;
    end
    return s[OUT_W-1:0];
  endfunction

  assign en           = !v[3] || corner_ready;
  assign dir_ready    = en;
  assign corner_valid = v[3];

  assign w_s = {1'b0, g0.w};
  assign h_s = {1'b0, g0.h};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[2:0], dir_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // undo the half-turn fold
      c0 <= dir_flip ? -dir_x : dir_x;
      s0 <= dir_flip ? -dir_y : dir_y;
      g0 <= dir_geom;

      cw1 <= c0 * w_s;
      sh1 <= s0 * h_s;
      sw1 <= s0 * w_s;
      ch1 <= c0 * h_s;
      g1  <= g0;

      // x' = c*ox - s*oy, y' = s*ox + c*oy with doubled offsets
      tlx2 <= SUM_W'(sh1) - SUM_W'(cw1);
      tly2 <= -SUM_W'(sw1) - SUM_W'(ch1);
      trx2 <= SUM_W'(cw1) + SUM_W'(sh1);
      try2 <= SUM_W'(sw1) - SUM_W'(ch1);
      brx2 <= SUM_W'(cw1) - SUM_W'(sh1);
      bry2 <= SUM_W'(sw1) + SUM_W'(ch1);
      blx2 <= -SUM_W'(cw1) - SUM_W'(sh1);
      bly2 <= SUM_W'(ch1) - SUM_W'(sw1);
      g2   <= g1;

      top_left_x     <= place(g2.cx, tlx2);
      top_left_y     <= place(g2.cy, tly2);
      top_right_x    <= place(g2.cx, trx2);
      top_right_y    <= place(g2.cy, try2);
      bottom_right_x <= place(g2.cx, brx2);
      bottom_right_y <= place(g2.cy, bry2);
      bottom_left_x  <= place(g2.cx, blx2);
      bottom_left_y  <= place(g2.cy, bly2);
    end
  end

endmodule

/* hdl/rotated_rect_corners_core.sv */
// Top level of the rotated rectangle corner generator: phase reduction,
// pipelined CORDIC and corner arithmetic. Depends on rrc_pkg, rrc_phase,
// rrc_cordic and rrc_corners.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-------------------------------------
//   rect     | rect_valid / rect_ready     | center_x, center_y, width, height,
//            |                             | angle
//   corner   | corner_valid / corner_ready | top_left_*, top_right_*,
//            |                             | bottom_right_*, bottom_left_*
//
// One item enters per cycle while rect_ready is high; each item passes through angle
// reduction, the CORDIC iterations and the corner arithmetic, in that order.
// The CORDIC depth sets most of the latency; throughput stays one item per cycle unless corner_ready stalls it.
// Reset (rst, synchronous) clears only the valid bits; no state survives an item.
// Each of the three sections advances as a unit: it holds when its last stage
// carries an item that the next section does not take, and the stall reaches
// rect_ready combinationally from corner_ready.
module rotated_rect_corners_core
  import rrc_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF  // 8 to 24 iterations
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    rect_valid,
  output logic                    rect_ready,
  input  logic signed [CX_W-1:0]  center_x,
  input  logic signed [CX_W-1:0]  center_y,
  input  logic [SIZE_W-1:0]       width,
  input  logic [SIZE_W-1:0]       height,
  input  logic signed [ANG_W-1:0] angle,
  output logic                    corner_valid,
  input  logic                    corner_ready,
  output logic signed [OUT_W-1:0] top_left_x,
  output logic signed [OUT_W-1:0] top_left_y,
  output logic signed [OUT_W-1:0] top_right_x,
  output logic signed [OUT_W-1:0] top_right_y,
  output logic signed [OUT_W-1:0] bottom_right_x,
  output logic signed [OUT_W-1:0] bottom_right_y,
  output logic signed [OUT_W-1:0] bottom_left_x,
  output logic signed [OUT_W-1:0] bottom_left_y
);

  // geometry rides along with the angle through every stage
  geom_t rect_geom;

  // phase section -> CORDIC
  logic                   ph_valid;
  logic                   ph_ready;
  logic signed [Z_W-1:0]  ph_z;
  logic                   ph_flip;
  geom_t                  ph_geom;

  // CORDIC -> corner section
  logic                   dir_valid;
  logic                   dir_ready;
  logic signed [XY_W-1:0] dir_x;
  logic signed [XY_W-1:0] dir_y;
  logic                   dir_flip;
  geom_t                  dir_geom;

  assign rect_geom.cx = center_x;
  assign rect_geom.cy = center_y;
  assign rect_geom.w  = width;
  assign rect_geom.h  = height;

  // Reduce the angle modulo 360 degrees and fold it into [-90, 90] degrees.
  rrc_phase u_phase (
    .clk        (clk),
    .rst        (rst),
    .rect_valid (rect_valid),
    .rect_ready (rect_ready),
    .angle      (angle),
    .rect_geom  (rect_geom),
    .ph_valid   (ph_valid),
    .ph_ready   (ph_ready),
    .ph_z       (ph_z),
    .ph_flip    (ph_flip),
    .ph_geom    (ph_geom)
  );

  // Turn the phase into a unit direction (cos, sin) in Q30.
  rrc_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .ph_valid  (ph_valid),
    .ph_ready  (ph_ready),
    .ph_z      (ph_z),
    .ph_flip   (ph_flip),
    .ph_geom   (ph_geom),
    .dir_valid (dir_valid),
    .dir_ready (dir_ready),
    .dir_x     (dir_x),
    .dir_y     (dir_y),
    .dir_flip  (dir_flip),
    .dir_geom  (dir_geom)
  );

  // Rotate the half-size offsets and add the center.
  rrc_corners u_corners (
    .clk            (clk),
    .rst            (rst),
    .dir_valid      (dir_valid),
    .dir_ready      (dir_ready),
    .dir_x          (dir_x),
    .dir_y          (dir_y),
    .dir_flip       (dir_flip),
    .dir_geom       (dir_geom),
    .corner_valid   (corner_valid),
    .corner_ready   (corner_ready),
    .top_left_x     (top_left_x),
    .top_left_y     (top_left_y),
    .top_right_x    (top_right_x),
    .top_right_y    (top_right_y),
    .bottom_right_x (bottom_right_x),
    .bottom_right_y (bottom_right_y),
    .bottom_left_x  (bottom_left_x),
    .bottom_left_y  (bottom_left_y)
  );

  // Opposite corners each sum to twice the center within one rounding step,
  // so the two diagonal sums differ by at most one.
  logic signed [OUT_W+1:0] diag_x;
  logic signed [OUT_W+1:0] diag_y;

  assign diag_x = (OUT_W+2)'(top_left_x) + (OUT_W+2)'(bottom_right_x)
                - (OUT_W+2)'(top_right_x) - (OUT_W+2)'(bottom_left_x);
  assign diag_y = (OUT_W+2)'(top_left_y) + (OUT_W+2)'(bottom_right_y)
                - (OUT_W+2)'(top_right_y) - (OUT_W+2)'(bottom_left_y);

  a_diag_x : assert property (@(posedge clk) disable iff (rst)
    corner_valid |-> (diag_x == 0 || diag_x == 1 || diag_x == -1))
    else $error("corner x diagonals disagree");

  a_diag_y : assert property (@(posedge clk) disable iff (rst)
    corner_valid |-> (diag_y == 0 || diag_y == 1 || diag_y == -1))
    else $error("corner y diagonals disagree");

  // an open output must open the whole pipeline back to the input
  a_ready_path : assert property (@(posedge clk) disable iff (rst)
    corner_ready |-> rect_ready)
    else $error("input held while output is open");

  // reset drops every item in flight
  a_reset_flush : assert property (@(posedge clk)
    rst |=> !corner_valid)
    else $error("item survived reset");

endmodule
